[design/hsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types, constants and elaboration-time helpers for the SECDED stream
// checker.
// ----------------------------------------------------------------------------
package hsc_pkg;

    // Register map: one register, selected by address bit 2.
    localparam logic REG_DATA_BITS = 1'b0;

    // Reset value of the data bit count.
    localparam logic [5:0] DATA_BITS_RESET = 6'd4;

    // Depth of the queue between the bit scanner and the counters.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Per-byte summary that the scanner hands to the counter stage.
    typedef struct packed {
        logic [2:0] singles;
        logic [2:0] doubles;
        logic       last;
        logic [5:0] dropped;
    } q_entry_t;

    // Number of check bits for a given data bit count.
    function automatic int check_count(input int d);
        int r;
        r = 1;
        while (r < 31 && (1 << r) < d + r + 1)
            r++;
        return r;
    endfunction

    // Codeword length for a data bit count, with the data bit count lowered
    // until the codeword fits in max_bits.
    function automatic int cw_len(input int d_in, input int max_bits);
        int d;
        d = d_in;
        while (d > 0 && d + check_count(d) + 1 > max_bits)
            d--;
        return d + check_count(d) + 1;
    endfunction

endpackage

[design/hsc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_in_if
// Byte channel into the checker: one byte of the file per request.
// ----------------------------------------------------------------------------
interface hsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, byte_in, last_byte, input ready);
    modport sink   (input valid, byte_in, last_byte, output ready);
endinterface

[design/hsc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_out_if
// Report channel out of the checker: one report per file.
// ----------------------------------------------------------------------------
interface hsc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] error_total;
    logic [31:0] single_blocks;
    logic [31:0] double_blocks;
    logic [5:0]  dropped_bits;

    modport source (output valid, error_total, single_blocks, double_blocks,
                    dropped_bits, input ready);
    modport sink   (input valid, error_total, single_blocks, double_blocks,
                    dropped_bits, output ready);
endinterface

[design/hsc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_front
// Bit scanner: walks the eight bits of each byte, keeps the running syndrome
// and parity of the open codeword, and classifies each codeword it closes.
// ----------------------------------------------------------------------------
module hsc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         byte_in,
    input  logic               last_byte,
    input  logic [5:0]         last_pos,
    output hsc_pkg::q_entry_t  entry
);

    logic [5:0] syndrome_reg, syndrome_next;
    logic       parity_reg, parity_next;
    logic [5:0] bit_index_reg, bit_index_next;

    logic [5:0] syn;
    logic       par;
    logic [5:0] idx;
    logic [2:0] n_single;
    logic [2:0] n_double;

    // Eight bit updates, most significant bit first.
    always_comb
    begin
        syn      = syndrome_reg;
        par      = parity_reg;
        idx      = bit_index_reg;
        n_single = 3'd0;
        n_double = 3'd0;
        for (int b = 7; b >= 0; b--)
        begin
            if (byte_in[b])
            begin
                syn = syn ^ idx;
                par = ~par;
            end
            if (idx >= last_pos)
            begin
                if (syn != 6'd0)
                begin
                    if (par)
                        n_single = n_single + 3'd1;
                    else
                        n_double = n_double + 3'd1;
                end
                syn = 6'd0;
                par = 1'b0;
                idx = 6'd0;
            end
            else
            begin
                idx = idx + 6'd1;
            end
        end
    end

    // Summary of this byte for the counter stage.
    always_comb
    begin
        entry.singles = n_single;
        entry.doubles = n_double;
        entry.last    = last_byte;
        entry.dropped = idx;
    end

    // The open codeword is discarded after the final byte of a file.
    always_comb
    begin
        syndrome_next  = syndrome_reg;
        parity_next    = parity_reg;
        bit_index_next = bit_index_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                syndrome_next  = 6'd0;
                parity_next    = 1'b0;
                bit_index_next = 6'd0;
            end
            else
            begin
                syndrome_next  = syn;
                parity_next    = par;
                bit_index_next = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            syndrome_reg  <= 6'd0;
            parity_reg    <= 1'b0;
            bit_index_reg <= 6'd0;
        end
        else
        begin
            syndrome_reg  <= syndrome_next;
            parity_reg    <= parity_next;
            bit_index_reg <= bit_index_next;
        end
    end

    // A file always starts on a fresh codeword.
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |=> (bit_index_reg == 6'd0 && syndrome_reg == 6'd0))
        else $error("scanner state not cleared after final byte");

endmodule

[design/hsc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_queue
// Small FIFO of per-byte summaries between the scanner and the counters.
// ----------------------------------------------------------------------------
module hsc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hsc_pkg::q_entry_t  push_data,
    input  logic               pop,
    output hsc_pkg::q_entry_t  head,
    output logic               full,
    output logic               empty
);

    localparam int PW = hsc_pkg::QPTR_W;

    hsc_pkg::q_entry_t  slot_reg [hsc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [PW:0]        level_reg, level_next;

    assign full  = (level_reg == (PW+1)'(hsc_pkg::QUEUE_DEPTH));
    assign empty = (level_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointer and fill level update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !pop)
            level_next = level_reg + (PW+1)'(1);
        else if (pop && !push)
            level_next = level_reg - (PW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue read while empty");

endmodule

[design/hsc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_back
// Counter stage: folds byte summaries into saturating counters and emits the
// report for a file into an output register.
// ----------------------------------------------------------------------------
module hsc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  hsc_pkg::q_entry_t  head,
    input  logic               empty,
    output logic               pop,
    hsc_out_if.source          out_ch
);

    logic [31:0] weighted_reg, weighted_next;
    logic [31:0] single_reg, single_next;
    logic [31:0] double_reg, double_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_total_reg, out_single_reg, out_double_reg;
    logic [5:0]  out_dropped_reg;

    logic [31:0] weighted_sum;
    logic [31:0] single_sum;
    logic [31:0] double_sum;
    logic [3:0]  weight;

    // Add a small amount, holding at all ones on overflow.
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [3:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {29'd0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // A final summary waits until the output register is free.
    assign pop = !empty && (!head.last || !out_valid_reg || out_ch.ready);

    assign weight       = {1'b0, head.singles} + {head.doubles, 1'b0};
    assign weighted_sum = sat_add(weighted_reg, weight);
    assign single_sum   = sat_add(single_reg, {1'b0, head.singles});
    assign double_sum   = sat_add(double_reg, {1'b0, head.doubles});

    // Counter update; the report takes the updated values and clears them.
    always_comb
    begin
        weighted_next  = weighted_reg;
        single_next    = single_reg;
        double_next    = double_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        if (pop)
        begin
            if (head.last)
            begin
                weighted_next  = 32'd0;
                single_next    = 32'd0;
                double_next    = 32'd0;
                out_valid_next = 1'b1;
            end
            else
            begin
                weighted_next = weighted_sum;
                single_next   = single_sum;
                double_next   = double_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weighted_reg  <= 32'd0;
            single_reg    <= 32'd0;
            double_reg    <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            weighted_reg  <= weighted_next;
            single_reg    <= single_next;
            double_reg    <= double_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Report payload.
    always_ff @(posedge clk)
    begin
        if (pop && head.last)
        begin
            out_total_reg   <= weighted_sum;
            out_single_reg  <= single_sum;
            out_double_reg  <= double_sum;
            out_dropped_reg <= head.dropped;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.error_total   = out_total_reg;
    assign out_ch.single_blocks = out_single_reg;
    assign out_ch.double_blocks = out_double_reg;
    assign out_ch.dropped_bits  = out_dropped_reg;

    // The weighted total never falls below either block count.
    a_total_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (weighted_reg >= single_reg) && (weighted_reg >= double_reg))
        else $error("weighted total below a block count");

endmodule

[design/hamming_secded_stream_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_secded_stream_checker
// Counts single and double errors in a byte stream read as extended Hamming
// codewords.
// ----------------------------------------------------------------------------
// Usage:
// Bytes of a file enter on in_ch, most significant bit first, with last_byte
// set on the final byte. Each byte is scanned combinationally, so the block
// takes one byte per clock while the queue has room; the eight-bit scan in the
// front stage sets that rate. A four-entry queue separates the scanner from the
// counter stage. The report is presented on out_ch from an output register once
// the final byte's summary has left the queue: error_total, single_blocks,
// double_blocks (all saturating) and dropped_bits, the bits of an unfinished
// trailing codeword. Every file gives exactly one report.
// If out_ch stalls, the pending report holds in its output register, later
// files keep streaming into the queue, and in_ch.ready drops once the queue
// fills behind a second final byte.
// The APB port writes data_bits at address 0; the codeword length is derived
// at the write. Reset sets data_bits to 4, clears all counters and empties the
// queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module hamming_secded_stream_checker #(
    parameter int MAX_CODEWORD_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    hsc_in_if.sink      in_ch,
    hsc_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [5:0] LAST_POS_RESET = 6'(hsc_pkg::cw_len(
        int'(hsc_pkg::DATA_BITS_RESET), MAX_CODEWORD_BITS) - 1);

    logic [5:0] data_bits_reg, data_bits_next;
    logic [5:0] last_pos_reg, last_pos_next;
    logic [5:0] last_pos_tab [64];
    logic       cfg_write;

    logic              accept;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    hsc_pkg::q_entry_t front_entry;
    hsc_pkg::q_entry_t q_head;

    // Last codeword position for each data bit count, fixed at elaboration.
    for (genvar g = 0; g < 64; g++)
    begin : g_len
        assign last_pos_tab[g] = 6'(hsc_pkg::cw_len(g, MAX_CODEWORD_BITS) - 1);
    end

    // Configuration register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == hsc_pkg::REG_DATA_BITS);
    assign prdata    = (paddr[2] == hsc_pkg::REG_DATA_BITS) ? {26'd0, data_bits_reg} : 32'd0;

    always_comb
    begin
        data_bits_next = data_bits_reg;
        last_pos_next  = last_pos_reg;
        if (cfg_write)
        begin
            data_bits_next = pwdata[5:0];
            last_pos_next  = last_pos_tab[pwdata[5:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_bits_reg <= hsc_pkg::DATA_BITS_RESET;
            last_pos_reg  <= LAST_POS_RESET;
        end
        else
        begin
            data_bits_reg <= data_bits_next;
            last_pos_reg  <= last_pos_next;
        end
    end

    // Input handshake: a byte is taken whenever the queue has room.
    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;

    hsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .byte_in   (in_ch.byte_in),
        .last_byte (in_ch.last_byte),
        .last_pos  (last_pos_reg),
        .entry     (front_entry)
    );

    hsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_entry),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    hsc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .empty  (q_empty),
        .pop    (q_pop),
        .out_ch (out_ch)
    );

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SECDED stream checker. Files of bytes, mostly
// built from valid extended Hamming codewords with zero to three flipped bits,
// are streamed in under random gaps and stalls. A local scanner predicts the
// report of each file, and every report on the output channel is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_CW     = 64;
    localparam int DRAIN_PAD  = 16;
    localparam int RANDOM_MIN = 500;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        logic [31:0] total;
        logic [31:0] singles;
        logic [31:0] doubles;
        logic [5:0]  dropped;
    } report_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hsc_in_if  in_ch ();
    hsc_out_if out_ch ();

    hamming_secded_stream_checker #(
        .MAX_CODEWORD_BITS (MAX_CW)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Scanner state mirrored from the block, plus its configuration.
    logic [5:0]  cfg_data_bits;
    logic [5:0]  cw_syndrome;
    logic        cw_parity;
    logic [5:0]  cw_pos;
    logic [31:0] err_weight;
    logic [31:0] single_cnt;
    logic [31:0] double_cnt;

    byte_item_t byte_backlog[$];
    report_t    pending_reports[$];

    int  fail_count = 0;
    int  bytes_queued = 0;
    bit  src_idle_on = 1'b0;
    bit  sink_idle_on = 1'b0;
    bit  hold_request = 1'b0;
    logic sink_hold = 1'b0;
    int  src_gap = 0;
    int  sink_stall = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Codeword length for a data bit count, lowered until it fits.
    function automatic int codeword_bits(input logic [5:0] d_cfg);
        int d;
        int r;
        for (d = d_cfg; d > 0; d--)
        begin
            r = 1;
            while ((2 ** r) - r - 1 < d)
                r++;
            if (d + r + 1 <= MAX_CW)
                return d + r + 1;
        end
        return 2;
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] a, input int k);
        logic [32:0] s;
        s = {1'b0, a} + k;
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Scan one accepted byte, MSB first; a final byte queues the file report.
    function automatic void scan_byte(input logic [7:0] data, input logic last);
        int      n;
        int      i;
        report_t rep;
        n = codeword_bits(cfg_data_bits);
        for (i = 7; i >= 0; i--)
        begin
            if (data[i])
            begin
                cw_syndrome ^= cw_pos;
                cw_parity ^= 1'b1;
            end
            if (int'(cw_pos) + 1 >= n)
            begin
                if (cw_syndrome != 6'd0)
                begin
                    if (cw_parity)
                    begin
                        err_weight = sat_inc(err_weight, 1);
                        single_cnt = sat_inc(single_cnt, 1);
                    end
                    else
                    begin
                        err_weight = sat_inc(err_weight, 2);
                        double_cnt = sat_inc(double_cnt, 1);
                    end
                end
                cw_syndrome = '0;
                cw_parity = 1'b0;
                cw_pos = '0;
            end
            else
                cw_pos = cw_pos + 6'd1;
        end
        if (last)
        begin
            rep.total   = err_weight;
            rep.singles = single_cnt;
            rep.doubles = double_cnt;
            rep.dropped = cw_pos;
            pending_reports.insert(pending_reports.size(), rep);
            cw_syndrome = '0;
            cw_parity = 1'b0;
            cw_pos = '0;
            err_weight = '0;
            single_cnt = '0;
            double_cnt = '0;
        end
    endfunction

    // Mostly short idle stretches, now and then a long one.
    function automatic int gap_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Byte driver: predicts on acceptance and loads the next request.
    always @(posedge clk)
    begin : byte_driver
        byte_item_t item;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                scan_byte(in_ch.byte_in, in_ch.last_byte);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (byte_backlog.size() != 0)
                begin
                    item = byte_backlog.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.byte_in <= item.data;
                    in_ch.last_byte <= item.last;
                    if (src_idle_on && $urandom_range(0, 3) == 0)
                        src_gap = gap_length();
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Report monitor: checks each accepted report and paces ready.
    always @(posedge clk)
    begin : report_monitor
        report_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            sink_stall = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected report: total %0d single %0d double %0d dropped %0d",
                                 out_ch.error_total, out_ch.single_blocks,
                                 out_ch.double_blocks, out_ch.dropped_bits);
                    fail_count++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (out_ch.error_total !== want.total
                        || out_ch.single_blocks !== want.singles
                        || out_ch.double_blocks !== want.doubles
                        || out_ch.dropped_bits !== want.dropped)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("report mismatch at %0t:", $realtime);
                            $display("  expected total %0d single %0d double %0d dropped %0d",
                                     want.total, want.singles, want.doubles, want.dropped);
                            $display("  actual   total %0d single %0d double %0d dropped %0d",
                                     out_ch.error_total, out_ch.single_blocks,
                                     out_ch.double_blocks, out_ch.dropped_bits);
                        end
                        fail_count++;
                    end
                end
            end
            if (sink_hold)
                out_ch.ready <= 1'b0;
            else if (sink_stall > 0)
            begin
                sink_stall--;
                out_ch.ready <= 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 3) == 0)
            begin
                sink_stall = gap_length() - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Long receiver hold-off, counted here while the sender keeps going.
    initial
    begin
        wait (hold_request);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (400) @(posedge clk);
        sink_hold <= 1'b0;
    end

    // Run limit.
    initial
    begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

    task automatic push_byte(input logic [7:0] data, input logic last);
        byte_item_t item;
        item.data = data;
        item.last = last;
        byte_backlog.insert(byte_backlog.size(), item);
        bytes_queued++;
    endtask

    // APB write of the data bit count: setup, then access until pready.
    task automatic write_data_bits(input logic [5:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {hsc_pkg::REG_DATA_BITS, 2'b00};
        pwdata  <= {26'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_data_bits = value;
    endtask

    // Wait until every request is taken and every report is in, then give
    // the block time to finish any byte that produces no report.
    task automatic settle();
        int guard;
        guard = 0;
        @(negedge clk);
        while ((byte_backlog.size() != 0 || in_ch.valid || pending_reports.size() != 0)
               && guard < 50000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (DRAIN_PAD) @(negedge clk);
    endtask

    // Queue one file built from valid codewords with a few flipped bits and
    // an optional ragged tail; closed marks its final byte.
    task automatic queue_coded_file(input bit closed);
        bit          bitstream[$];
        logic [63:0] cw;
        logic [63:0] flipped;
        logic [5:0]  syn;
        logic [7:0]  data;
        int          n;
        int          words;
        int          k;
        int          p;
        int          f;
        int          flips;
        int          nbytes;
        n = codeword_bits(cfg_data_bits);
        words = $urandom_range(0, 96 / n);
        for (k = 0; k < words; k++)
        begin
            cw = '0;
            for (p = 3; p < n; p++)
                if ((p & (p - 1)) != 0)
                    cw[p] = 1'($urandom_range(0, 1));
            syn = '0;
            for (p = 1; p < n; p++)
                if (cw[p])
                    syn ^= p[5:0];
            for (p = 0; p < 6; p++)
                if (syn[p])
                    cw[1 << p] = 1'b1;
            cw[0] = ^cw[63:1];
            f = $urandom_range(0, 9);
            flips = (f < 3) ? 0 : (f < 6) ? 1 : (f < 9) ? 2 : 3;
            if (flips > n)
                flips = n;
            flipped = '0;
            for (f = 0; f < flips; f++)
            begin
                do p = $urandom_range(0, n - 1); while (flipped[p]);
                flipped[p] = 1'b1;
                cw[p] = ~cw[p];
            end
            for (p = 0; p < n; p++)
                bitstream.insert(bitstream.size(), cw[p]);
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, n - 1))
                bitstream.insert(bitstream.size(), 1'($urandom_range(0, 1)));
        while (bitstream.size() == 0 || bitstream.size() % 8 != 0)
            bitstream.insert(bitstream.size(), 1'($urandom_range(0, 1)));
        nbytes = bitstream.size() / 8;
        for (k = 0; k < nbytes; k++)
        begin
            for (p = 0; p < 8; p++)
                data[7 - p] = bitstream[8 * k + p];
            push_byte(data, closed && k == nbytes - 1);
        end
    endtask

    task automatic queue_noise_file(input int len);
        int k;
        for (k = 0; k < len; k++)
            push_byte(8'($urandom_range(0, 255)), k == len - 1);
    endtask

    // Main sequence: directed cases, then random phases over several settings.
    initial
    begin : main_sequence
        logic [5:0] settings[6];
        int phase;
        int phase_start;
        int pick;
        settings = '{6'd4, 6'd57, 6'd0, 6'd63, 6'd1, 6'd26};
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.byte_in = '0;
        in_ch.last_byte = 1'b0;
        out_ch.ready = 1'b0;
        cfg_data_bits = hsc_pkg::DATA_BITS_RESET;
        cw_syndrome = '0;
        cw_parity = 1'b0;
        cw_pos = '0;
        err_weight = '0;
        single_cnt = '0;
        double_cnt = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Default eight-bit codewords: clean, parity-only, single, double.
        @(negedge clk);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h40, 1'b1);
        push_byte(8'h60, 1'b1);
        push_byte(8'h80, 1'b0);
        push_byte(8'h40, 1'b0);
        push_byte(8'h60, 1'b0);
        push_byte(8'h01, 1'b1);
        settle();

        // Zero data bits gives two-bit codewords.
        write_data_bits(6'd0);
        @(negedge clk);
        push_byte(8'h55, 1'b1);
        push_byte(8'hC3, 1'b0);
        push_byte(8'h0F, 1'b1);
        settle();

        // Oversized setting acts as the largest codeword; one byte is dropped.
        write_data_bits(6'd63);
        @(negedge clk);
        push_byte(8'hFF, 1'b1);
        settle();

        // Shrink the codeword while one is partly done; it closes on the next bit.
        write_data_bits(6'd57);
        @(negedge clk);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b0);
        push_byte(8'h56, 1'b0);
        settle();
        write_data_bits(6'd1);
        @(negedge clk);
        push_byte(8'hA5, 1'b1);
        settle();

        // Random phases.
        bytes_queued = 0;
        phase = 0;
        while (bytes_queued < RANDOM_MIN)
        begin
            if (phase < 6)
                write_data_bits(settings[phase]);
            else
                write_data_bits(6'($urandom_range(0, 63)));
            @(negedge clk);
            if (phase == 2)
            begin
                // Receiver holds off while short files keep arriving back to back.
                src_idle_on = 1'b0;
                sink_idle_on = 1'b0;
                hold_request = 1'b1;
                repeat (30) queue_noise_file($urandom_range(1, 2));
            end
            else
            begin
                src_idle_on = (phase % 3 != 0);
                sink_idle_on = (phase % 4 != 1);
            end
            phase_start = bytes_queued;
            while (bytes_queued - phase_start < 60)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    queue_coded_file(1'b1);
                else if (pick < 9)
                    queue_noise_file($urandom_range(1, 6));
                else
                    queue_coded_file(1'b0);
            end
            settle();
            phase++;
        end

        settle();
        if (pending_reports.size() != 0)
        begin
            if (fail_count < 10)
                $display("%0d reports never arrived", pending_reports.size());
            fail_count += pending_reports.size();
        end
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
